/* hdl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the LRU buffer cache.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int NUM_ENTRIES_DEF = 32;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int DEV_W           = 8;
    localparam int IN_KEY_W        = 32;
    localparam int IDX_W           = 5;
    localparam int CNT_W           = 8;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INVAL   = 2'd2,
        OP_SETFLG  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_HIT    = 3'd0,
        ST_ALLOC  = 3'd1,
        ST_NOBUF  = 3'd2,
        ST_DONE   = 3'd3,
        ST_UNREF  = 3'd4
    } t_status;

    typedef struct packed {
        t_op                  op;
        logic [DEV_W-1:0]     device;
        logic [IN_KEY_W-1:0]  block_key;
        logic                 no_cache;
        logic [IDX_W-1:0]     entry_index;
        logic                 valid_in;
        logic                 dirty_in;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [IDX_W-1:0]     entry_out;
        logic                 valid_out;
        logic                 dirty_out;
    } t_result;

endpackage

/* hdl/bbc_ram.sv */
// ----------------------------------------------------------------------------
// bbc_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hdl/bbc_ctrl.sv */
// ----------------------------------------------------------------------------
// bbc_ctrl
// Sequencer of the buffer cache: tag scan, read-modify-write of entries,
// recency moves and the clearing pass, plus the result register.
// ----------------------------------------------------------------------------
module bbc_ctrl #(
    parameter int NUM_ENTRIES = bbc_pkg::NUM_ENTRIES_DEF,
    parameter int KEY_WIDTH   = bbc_pkg::KEY_WIDTH_DEF,
    localparam int IW = $clog2(NUM_ENTRIES),
    localparam int EW = KEY_WIDTH + bbc_pkg::DEV_W + 3 + bbc_pkg::CNT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  bbc_pkg::t_req    i_req,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output bbc_pkg::t_result o_res,
    output logic             o_ent_we,
    output logic [IW-1:0]    o_ent_waddr,
    output logic [EW-1:0]    o_ent_wdata,
    output logic [IW-1:0]    o_ent_raddr,
    input  logic [EW-1:0]    i_ent_rdata,
    output logic             o_ord_we,
    output logic [IW-1:0]    o_ord_waddr,
    output logic [IW-1:0]    o_ord_wdata,
    output logic [IW-1:0]    o_ord_raddr,
    input  logic [IW-1:0]    i_ord_rdata
);

    localparam int DV = bbc_pkg::DEV_W;
    localparam int VB = KEY_WIDTH + DV;
    localparam int DB = VB + 1;
    localparam int NB = VB + 2;
    localparam int CB = VB + 3;
    localparam logic [IW-1:0] LAST = IW'(NUM_ENTRIES - 1);
    localparam logic [bbc_pkg::CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_GSCAN, S_GWR, S_RRD, S_RMOD, S_MOVE,
        S_INV, S_SRD, S_SWR, S_DONE
    } t_state;

    t_state                   r_state;
    logic [DV-1:0]            r_dev;
    logic [KEY_WIDTH-1:0]     r_key;
    logic                     r_nc;
    logic [bbc_pkg::IDX_W-1:0] r_idx;
    logic                     r_vin;
    logic                     r_din;
    logic [IW-1:0]            r_ra;
    logic                     r_p1;
    logic [IW-1:0]            r_rk1;
    logic                     r_p2;
    logic [IW-1:0]            r_e2;
    logic [IW-1:0]            r_n2;
    logic [IW-1:0]            r_cand;
    logic                     r_cok;
    logic [IW-1:0]            r_sel;
    logic [EW-1:0]            r_word;
    logic                     r_front;
    logic [IW-1:0]            r_carry;
    bbc_pkg::t_result         r_res;
    logic                     r_ov;
    bbc_pkg::t_result         r_out;

    logic                     idx_ok;
    logic [IW-1:0]            idx_e;
    logic                     match;
    logic                     free;
    logic                     inv_hit;
    logic [bbc_pkg::CNT_W-1:0] cnt_rd;
    logic [bbc_pkg::CNT_W-1:0] cnt_dec;

    assign idx_ok  = 32'(r_idx) < NUM_ENTRIES;
    assign idx_e   = IW'(r_idx);
    assign match   = (i_ent_rdata[DV-1:0] == r_dev) &&
                     (i_ent_rdata[DV +: KEY_WIDTH] == r_key);
    assign cnt_rd  = i_ent_rdata[CB +: bbc_pkg::CNT_W];
    assign free    = (cnt_rd == '0) && !i_ent_rdata[DB];
    assign cnt_dec = cnt_rd - 1'b1;
    assign inv_hit = i_ent_rdata[DV-1:0] == r_dev;

    assign o_req_ready = r_state == S_IDLE;
    assign o_res_valid = r_ov;
    assign o_res       = r_out;

    always_comb begin
        o_ent_we    = 1'b0;
        o_ent_waddr = r_sel;
        o_ent_wdata = i_ent_rdata;
        o_ent_raddr = r_ra;
        o_ord_we    = 1'b0;
        o_ord_waddr = r_rk1;
        o_ord_wdata = r_carry;
        o_ord_raddr = r_ra;
        unique case (r_state)
            S_CLR: begin
                o_ent_we    = 1'b1;
                o_ent_waddr = r_ra;
                o_ent_wdata = '0;
                o_ord_we    = 1'b1;
                o_ord_waddr = r_ra;
                o_ord_wdata = LAST - r_ra;
            end
            S_GSCAN: begin
                o_ent_raddr = i_ord_rdata;
            end
            S_GWR: begin
                o_ent_waddr = r_sel;
                if (r_res.status == bbc_pkg::ST_HIT) begin
                    o_ent_we    = 1'b1;
                    o_ent_wdata = r_word;
                    if (r_word[CB +: bbc_pkg::CNT_W] != CNT_MAX) begin
                        o_ent_wdata[CB +: bbc_pkg::CNT_W] =
                            r_word[CB +: bbc_pkg::CNT_W] + 1'b1;
                    end
                end else if (r_res.status == bbc_pkg::ST_ALLOC) begin
                    o_ent_we    = 1'b1;
                    o_ent_wdata = {bbc_pkg::CNT_W'(1), r_nc, 1'b0, 1'b0, r_key, r_dev};
                end
            end
            S_RRD, S_SRD: begin
                o_ent_raddr = idx_e;
            end
            S_RMOD: begin
                o_ent_waddr = idx_e;
                o_ent_we    = cnt_rd != '0;
                o_ent_wdata[CB +: bbc_pkg::CNT_W] = cnt_dec;
            end
            S_SWR: begin
                o_ent_waddr = idx_e;
                o_ent_we    = 1'b1;
                o_ent_wdata[VB] = r_vin;
                o_ent_wdata[DB] = r_din;
            end
            S_INV: begin
                o_ent_waddr = r_rk1;
                o_ent_we    = r_p1 && inv_hit;
                o_ent_wdata[VB] = 1'b0;
                o_ent_wdata[DB] = 1'b0;
            end
            S_MOVE: begin
                o_ord_we = r_p1;
            end
            S_IDLE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ra    <= '0;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_res_ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_ra <= r_ra + 1'b1;
                    if (r_ra == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_ra  <= '0;
                    r_p1  <= 1'b0;
                    r_p2  <= 1'b0;
                    r_n2  <= '0;
                    r_cok <= 1'b0;
                    if (i_req_valid) begin
                        r_dev <= i_req.device;
                        r_key <= KEY_WIDTH'(i_req.block_key);
                        r_nc  <= i_req.no_cache;
                        r_idx <= i_req.entry_index;
                        r_vin <= i_req.valid_in;
                        r_din <= i_req.dirty_in;
                        unique case (i_req.op)
                            bbc_pkg::OP_GET:     r_state <= S_GSCAN;
                            bbc_pkg::OP_RELEASE: r_state <= S_RRD;
                            bbc_pkg::OP_INVAL:   r_state <= S_INV;
                            bbc_pkg::OP_SETFLG:  r_state <= S_SRD;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_GSCAN: begin
                    r_ra <= r_ra + 1'b1;
                    r_p1 <= 1'b1;
                    r_p2 <= r_p1;
                    r_e2 <= i_ord_rdata;
                    if (r_p2) begin
                        r_n2 <= r_n2 + 1'b1;
                        if (match) begin
                            r_word     <= i_ent_rdata;
                            r_sel      <= r_e2;
                            r_res      <= '{bbc_pkg::ST_HIT, bbc_pkg::IDX_W'(r_e2),
                                            i_ent_rdata[VB], i_ent_rdata[DB]};
                            r_state    <= S_GWR;
                        end else begin
                            if (free) begin
                                r_cand <= r_e2;
                                r_cok  <= 1'b1;
                            end
                            if (r_n2 == LAST) begin
                                r_state <= S_GWR;
                                r_sel   <= free ? r_e2 : r_cand;
                                if (free || r_cok) begin
                                    r_res <= '{bbc_pkg::ST_ALLOC,
                                               bbc_pkg::IDX_W'(free ? r_e2 : r_cand),
                                               1'b0, 1'b0};
                                end else begin
                                    r_res <= '{bbc_pkg::ST_NOBUF, '0, 1'b0, 1'b0};
                                end
                            end
                        end
                    end
                end
                S_GWR: begin
                    r_state <= S_DONE;
                end
                S_RRD: begin
                    if (idx_ok) begin
                        r_state <= S_RMOD;
                    end else begin
                        r_res   <= '{bbc_pkg::ST_UNREF, r_idx, 1'b0, 1'b0};
                        r_state <= S_DONE;
                    end
                end
                S_RMOD: begin
                    r_state <= S_DONE;
                    if (cnt_rd == '0) begin
                        r_res <= '{bbc_pkg::ST_UNREF, r_idx,
                                   i_ent_rdata[VB], i_ent_rdata[DB]};
                    end else begin
                        r_res <= '{bbc_pkg::ST_DONE, r_idx,
                                   i_ent_rdata[VB], i_ent_rdata[DB]};
                        if (cnt_dec == '0) begin
                            r_front <= !i_ent_rdata[NB];
                            r_ra    <= i_ent_rdata[NB] ? LAST : '0;
                            r_carry <= idx_e;
                            r_p1    <= 1'b0;
                            r_state <= S_MOVE;
                        end
                    end
                end
                S_MOVE: begin
                    r_p1  <= 1'b1;
                    r_rk1 <= r_ra;
                    r_ra  <= r_front ? r_ra + 1'b1 : r_ra - 1'b1;
                    if (r_p1) begin
                        r_carry <= i_ord_rdata;
                        if (i_ord_rdata == idx_e) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_INV: begin
                    r_p1  <= 1'b1;
                    r_rk1 <= r_ra;
                    r_ra  <= r_ra + 1'b1;
                    if (r_p1 && r_rk1 == LAST) begin
                        r_res   <= '{bbc_pkg::ST_DONE, '0, 1'b0, 1'b0};
                        r_state <= S_DONE;
                    end
                end
                S_SRD: begin
                    if (idx_ok) begin
                        r_state <= S_SWR;
                    end else begin
                        r_res   <= '{bbc_pkg::ST_DONE, r_idx, 1'b0, 1'b0};
                        r_state <= S_DONE;
                    end
                end
                S_SWR: begin
                    r_res   <= '{bbc_pkg::ST_DONE, r_idx, r_vin, r_din};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || i_res_ready) begin
                        r_out   <= r_res;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/block_buffer_cache_lru_top.sv */
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_top
// LRU buffer cache with tags, marks, reference counts and a recency order.
// ----------------------------------------------------------------------------
// One request is handled at a time. Entry state lives in one RAM and the
// recency order in another, both with registered reads. A get walks the
// recency order through a two-stage read pipeline; a release moves the entry
// in the order when its count reaches zero; invalidate scans every entry.
// After reset a clearing pass over all NUM_ENTRIES entries initializes both
// RAMs before the first request is taken. A new request is accepted while
// the previous result waits.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_top #(
    parameter int NUM_ENTRIES = bbc_pkg::NUM_ENTRIES_DEF,
    parameter int KEY_WIDTH   = bbc_pkg::KEY_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // device[7:0], block_key[39:8], no_cache[40], entry_index[45:41],
    // valid_in[46], dirty_in[47]
    input  logic [47:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // entry_out[4:0], valid_out[5], dirty_out[6], zero[7]
    output logic [7:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int EW = KEY_WIDTH + bbc_pkg::DEV_W + 3 + bbc_pkg::CNT_W;

    bbc_pkg::t_req    req;
    bbc_pkg::t_result res;
    logic             ent_we;
    logic [IW-1:0]    ent_waddr;
    logic [EW-1:0]    ent_wdata;
    logic [IW-1:0]    ent_raddr;
    logic [EW-1:0]    ent_rdata;
    logic             ord_we;
    logic [IW-1:0]    ord_waddr;
    logic [IW-1:0]    ord_wdata;
    logic [IW-1:0]    ord_raddr;
    logic [IW-1:0]    ord_rdata;

    assign req.op          = bbc_pkg::t_op'(s_axis_tuser);
    assign req.device      = s_axis_tdata[7:0];
    assign req.block_key   = s_axis_tdata[39:8];
    assign req.no_cache    = s_axis_tdata[40];
    assign req.entry_index = s_axis_tdata[45:41];
    assign req.valid_in    = s_axis_tdata[46];
    assign req.dirty_in    = s_axis_tdata[47];

    assign m_axis_tdata = {1'b0, res.dirty_out, res.valid_out, res.entry_out};
    assign m_axis_tuser = res.status;

    bbc_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    bbc_ram #(.WIDTH(IW), .DEPTH(NUM_ENTRIES)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    bbc_ctrl #(.NUM_ENTRIES(NUM_ENTRIES), .KEY_WIDTH(KEY_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res),
        .o_ent_we    (ent_we),
        .o_ent_waddr (ent_waddr),
        .o_ent_wdata (ent_wdata),
        .o_ent_raddr (ent_raddr),
        .i_ent_rdata (ent_rdata),
        .o_ord_we    (ord_we),
        .o_ord_waddr (ord_waddr),
        .o_ord_wdata (ord_wdata),
        .o_ord_raddr (ord_raddr),
        .i_ord_rdata (ord_rdata)
    );

endmodule

/* test/tb_block_buffer_cache_lru_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru_top
// Checks the LRU buffer cache against a behavioral copy of its entry table,
// its reference counts and its recency order. A directed table runs first,
// then random get, release, invalidate and set-flag sequences over a small
// working set of tags, with random bursts of idling on both sides and a
// stretch of long output stalls.
module tb_block_buffer_cache_lru_top;
    import bbc_pkg::*;

    localparam int NENT = 32;
    localparam int N_RANDOM = 1330;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_op         op;
        logic [7:0]  device;
        logic [31:0] block_key;
        logic        no_cache;
        logic [4:0]  entry_index;
        logic        valid_in;
        logic        dirty_in;
        logic        known;
        t_result     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    block_buffer_cache_lru_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0]  c_dev [NENT];
    logic [31:0] c_key [NENT];
    logic        c_valid [NENT];
    logic        c_dirty [NENT];
    logic        c_nc [NENT];
    logic [7:0]  c_cnt [NENT];
    int          c_rank [NENT];

    t_result     pending_results[$];
    int          errors = 0;
    int          cycles = 0;
    bit          src_done = 0;
    bit          calm = 0;
    bit          hold_sink = 0;
    logic [7:0]  pool_dev [8];
    logic [31:0] pool_key [8];

    function automatic void cache_reset();
        for (int i = 0; i < NENT; i++) begin
            c_dev[i] = '0; c_key[i] = '0; c_valid[i] = 0; c_dirty[i] = 0;
            c_nc[i] = 0; c_cnt[i] = '0; c_rank[i] = NENT - 1 - i;
        end
    endfunction

    function automatic void cache_move(int e, bit to_front);
        int p;
        p = 0;
        while (p < NENT && c_rank[p] != e) p++;
        if (to_front) begin
            for (int i = p; i > 0; i--) c_rank[i] = c_rank[i-1];
            c_rank[0] = e;
        end else begin
            for (int i = p; i + 1 < NENT; i++) c_rank[i] = c_rank[i+1];
            c_rank[NENT-1] = e;
        end
    endfunction

    function automatic t_result cache_apply(t_row r);
        t_result o;
        int e;
        o = '{status: ST_DONE, entry_out: r.entry_index, valid_out: 0, dirty_out: 0};
        case (r.op)
            OP_GET: begin
                for (int p = 0; p < NENT; p++) begin
                    e = c_rank[p];
                    if (c_dev[e] == r.device && c_key[e] == r.block_key) begin
                        if (c_cnt[e] != 8'hFF) c_cnt[e]++;
                        return '{ST_HIT, e[4:0], c_valid[e], c_dirty[e]};
                    end
                end
                for (int p = NENT - 1; p >= 0; p--) begin
                    e = c_rank[p];
                    if (c_cnt[e] == 0 && !c_dirty[e]) begin
                        c_dev[e] = r.device; c_key[e] = r.block_key;
                        c_valid[e] = 0; c_dirty[e] = 0; c_nc[e] = r.no_cache;
                        c_cnt[e] = 1;
                        return '{ST_ALLOC, e[4:0], 1'b0, 1'b0};
                    end
                end
                o = '{ST_NOBUF, 5'd0, 1'b0, 1'b0};
            end
            OP_RELEASE: begin
                e = r.entry_index;
                o.valid_out = c_valid[e];
                o.dirty_out = c_dirty[e];
                if (c_cnt[e] == 0) begin
                    o.status = ST_UNREF;
                end else begin
                    c_cnt[e]--;
                    if (c_cnt[e] == 0) cache_move(e, !c_nc[e]);
                end
            end
            OP_INVAL: begin
                for (int i = 0; i < NENT; i++)
                    if (c_dev[i] == r.device) begin
                        c_valid[i] = 0; c_dirty[i] = 0;
                    end
                o.entry_out = '0;
            end
            default: begin
                e = r.entry_index;
                c_valid[e] = r.valid_in; c_dirty[e] = r.dirty_in;
                o.valid_out = r.valid_in; o.dirty_out = r.dirty_in;
            end
        endcase
        return o;
    endfunction

    function automatic t_row mk(t_op op, logic [7:0] d, logic [31:0] k, logic nc,
                                logic [4:0] ix, logic v, logic dt);
        t_row r;
        r = '{op: op, device: d, block_key: k, no_cache: nc, entry_index: ix,
              valid_in: v, dirty_in: dt, known: 0, res: '0};
        return r;
    endfunction

    function automatic t_row mkx(t_row r, t_status st, logic [4:0] e, logic v, logic d);
        r.known = 1;
        r.res = '{st, e, v, d};
        return r;
    endfunction

    task automatic send_beat(t_row r);
        t_result want;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tdata <= {r.dirty_in, r.valid_in, r.entry_index, r.no_cache,
                         r.block_key, r.device};
        s_axis_tuser <= r.op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = cache_apply(r);
        if (r.known && want != r.res) begin
            $display("%0t table row disagrees: expected %p predicted %p", $time, r.res, want);
            errors++;
        end
        pending_results.push_back(r.known ? r.res : want);
    endtask

    function automatic t_row rand_row();
        t_row r;
        int k, sel;
        k = $urandom_range(0, 7);
        sel = $urandom_range(0, 99);
        r = mk(OP_GET, pool_dev[k], pool_key[k], $urandom_range(0, 1),
               $urandom_range(0, NENT - 1), $urandom_range(0, 1), $urandom_range(0, 1));
        if (sel < 10) begin
            r.device = $urandom;
            r.block_key = $urandom;
        end else if (sel < 40) begin
        end else if (sel < 80) begin
            r.op = OP_RELEASE;
        end else if (sel < 88) begin
            r.op = OP_INVAL;
            if ($urandom_range(0, 3) == 0) r.device = $urandom;
        end else begin
            r.op = OP_SETFLG;
            if ($urandom_range(0, 1)) r.dirty_in = 0;
        end
        if (r.op == OP_RELEASE && $urandom_range(0, 1)) begin
            // aim about half of the releases at referenced entries
            for (int t = 0; t < 8; t++) begin
                k = $urandom_range(0, NENT - 1);
                if (c_cnt[k] != 0) begin
                    r.entry_index = k;
                    break;
                end
            end
        end
        return r;
    endfunction

    initial begin
        t_row tbl[$];
        cache_reset();
        for (int i = 0; i < 8; i++) begin
            pool_dev[i] = (i < 4) ? 8'h00 : $urandom;
            pool_key[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
        end
        pool_dev[1] = 8'hFF;
        tbl.push_back(mkx(mk(OP_GET, 8'h00, 32'h0, 0, 0, 0, 0), ST_HIT, 5'd31, 0, 0));
        tbl.push_back(mkx(mk(OP_GET, 8'hFF, 32'hFFFF_FFFF, 1, 31, 1, 1), ST_ALLOC, 5'd0, 0, 0));
        tbl.push_back(mkx(mk(OP_SETFLG, 8'h00, 32'h0, 0, 31, 1, 1), ST_DONE, 5'd31, 1, 1));
        tbl.push_back(mkx(mk(OP_SETFLG, 8'h00, 32'h0, 0, 0, 1, 1), ST_DONE, 5'd0, 1, 1));
        tbl.push_back(mkx(mk(OP_GET, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0), ST_HIT, 5'd0, 1, 1));
        tbl.push_back(mkx(mk(OP_RELEASE, 8'h00, 32'h0, 0, 5, 0, 0), ST_UNREF, 5'd5, 0, 0));
        tbl.push_back(mkx(mk(OP_INVAL, 8'hFF, 32'h0, 0, 7, 1, 1), ST_DONE, 5'd0, 0, 0));
        tbl.push_back(mk(OP_RELEASE, 8'h00, 32'h0, 0, 1, 0, 0));
        tbl.push_back(mk(OP_RELEASE, 8'h00, 32'h0, 0, 1, 0, 0));
        tbl.push_back(mk(OP_RELEASE, 8'h00, 32'h0, 0, 0, 0, 0));
        tbl.push_back(mk(OP_GET, 8'h5A, 32'h1234_5678, 0, 0, 0, 0));
        tbl.push_back(mk(OP_GET, 8'h00, 32'h0, 0, 0, 0, 0));
        tbl.push_back(mk(OP_SETFLG, 8'h00, 32'h0, 0, 2, 0, 1));
        tbl.push_back(mk(OP_INVAL, 8'h00, 32'h0, 0, 0, 0, 0));
        // fill every entry to reach the no-free-buffer case
        for (int i = 0; i < 34; i++)
            tbl.push_back(mk(OP_GET, 8'hA0, i, i[0], 0, 0, 0));
        for (int i = 0; i < NENT; i++)
            tbl.push_back(mk(OP_RELEASE, 8'h00, 32'h0, 0, i, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (tbl[i]) send_beat(tbl[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_sink = 1;
            if (n == 230) hold_sink = 0;
            if (n == N_RANDOM - 150) calm = 1;
            send_beat(rand_row());
        end
        s_axis_tvalid <= 1'b0;
        src_done = 1;
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                gap = 0;
                while (gap < 600) begin
                    @(posedge i_clk);
                    gap++;
                end
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{t_status'(m_axis_tuser), m_axis_tdata[4:0], m_axis_tdata[5],
                    m_axis_tdata[6]};
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %p", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status) begin
                    $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.entry_out != want.entry_out) begin
                    $display("%0t entry: expected %0d actual %0d", $time, want.entry_out,
                             got.entry_out);
                    errors++;
                end
                if (got.valid_out != want.valid_out || got.dirty_out != want.dirty_out) begin
                    $display("%0t valid/dirty: expected %b%b actual %b%b", $time,
                             want.valid_out, want.dirty_out, got.valid_out, got.dirty_out);
                    errors++;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
            if (src_done && pending_results.size() == 0) begin
                repeat (100) @(posedge i_clk);
                if (errors == 0 && pending_results.size() == 0)
                    $display("Regression PASS");
                else
                    $display("Regression FAIL");
                $finish;
            end
        end
    end
endmodule

/* block_buffer_cache_lru_top.f */
hdl/bbc_pkg.sv
hdl/bbc_ram.sv
hdl/bbc_ctrl.sv
hdl/block_buffer_cache_lru_top.sv
test/tb_block_buffer_cache_lru_top.sv
